// ===== hw/rtl/matching_message_channel_top_assert.svh =====
// Assertion macros used by the checker file mmc_checker.sv.
`ifndef MATCHING_MESSAGE_CHANNEL_TOP_ASSERT_SVH
`define MATCHING_MESSAGE_CHANNEL_TOP_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define MMC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mmc check failed");

// Condition in one cycle implies a condition in the next cycle.
`define MMC_ASSERT_NEXT(label, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("mmc sequence check failed");

`endif

// ===== hw/rtl/mmc_pkg.sv =====
package mmc_pkg;

	localparam int MAX_FIELDS  = 4;
	localparam int FIELD_WIDTH = 32;
	localparam int NF_W        = 3;

	typedef logic [FIELD_WIDTH-1:0] field_t;
	typedef field_t [MAX_FIELDS-1:0] row_t;

	localparam logic [1:0] CMD_APPEND  = 2'd0;
	localparam logic [1:0] CMD_SORTED  = 2'd1;
	localparam logic [1:0] CMD_RECEIVE = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_BLOCKED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_FIELDS   = 2'd1;
	localparam logic [1:0] REG_DROP     = 2'd2;

	localparam logic [2:0] IDX_HOLD  = 3'd0;
	localparam logic [2:0] IDX_ZERO  = 3'd1;
	localparam logic [2:0] IDX_COUNT = 3'd2;
	localparam logic [2:0] IDX_INC   = 3'd3;
	localparam logic [2:0] IDX_DEC   = 3'd4;

	localparam logic [1:0] RD_CUR  = 2'd0;
	localparam logic [1:0] RD_PREV = 2'd1;
	localparam logic [1:0] RD_NEXT = 2'd2;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_val;
		logic       wr_row;
		logic [2:0] idx_op;
		logic       pos_set;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       got_ld;
		logic       finish;
		logic [1:0] res_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       rnd;
		logic       poll;
		logic       commit;
		logic       drop;
		logic       full;
		logic       empty;
		logic       at_count;
		logic       at_pos;
		logic       last;
		logic       lt;
		logic       match;
	} dp_stat_t;

endpackage

// ===== hw/rtl/mmc_ctrl.sv =====
module mmc_ctrl
	import mmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_APP  = 4'd2;
	localparam logic [3:0] S_SRD  = 4'd3;
	localparam logic [3:0] S_SCMP = 4'd4;
	localparam logic [3:0] S_SHF  = 4'd5;
	localparam logic [3:0] S_SHW  = 4'd6;
	localparam logic [3:0] S_RRD  = 4'd7;
	localparam logic [3:0] S_RCMP = 4'd8;
	localparam logic [3:0] S_RSH  = 4'd9;
	localparam logic [3:0] S_RSW  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.idx_op = IDX_HOLD;
		cmd.rd_sel = RD_CUR;
		cmd.res_status = ST_DONE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (stat.command)
					CMD_APPEND, CMD_SORTED: begin
						if (stat.full) begin
							cmd.finish = 1'b1;
							cmd.res_status = stat.drop ? ST_DROPPED : ST_BLOCKED;
							state_d = S_IDLE;
						end else if (!stat.commit) begin
							cmd.finish = 1'b1;
							state_d = S_IDLE;
						end else if (stat.command == CMD_APPEND) begin
							cmd.idx_op = IDX_COUNT;
							state_d = S_APP;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d = S_SRD;
						end
					end
					CMD_RECEIVE: begin
						if (stat.empty) begin
							cmd.finish = 1'b1;
							cmd.res_status = ST_BLOCKED;
							state_d = S_IDLE;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d = S_RRD;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.res_status = ST_BLOCKED;
						state_d = S_IDLE;
					end
				endcase
			end
			S_APP: begin
				cmd.wr_val = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			S_SRD: begin
				if (stat.at_count) begin
					cmd.pos_set = 1'b1;
					state_d = S_SHF;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				// first stored message greater than the new one marks the slot
				if (stat.lt) begin
					cmd.pos_set = 1'b1;
					cmd.idx_op = IDX_COUNT;
					state_d = S_SHF;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d = S_SRD;
				end
			end
			S_SHF: begin
				if (stat.at_pos) begin
					cmd.wr_val = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d = S_SHW;
				end
			end
			S_SHW: begin
				cmd.wr_row = 1'b1;
				cmd.idx_op = IDX_DEC;
				state_d = S_SHF;
			end
			S_RRD: begin
				cmd.rd_en = 1'b1;
				state_d = S_RCMP;
			end
			S_RCMP: begin
				if (stat.match) begin
					if (!stat.commit) begin
						cmd.finish = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.got_ld = 1'b1;
						if (stat.poll) begin
							cmd.finish = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_RSH;
						end
					end
				end else if (stat.rnd && !stat.last) begin
					cmd.idx_op = IDX_INC;
					state_d = S_RRD;
				end else begin
					cmd.finish = 1'b1;
					cmd.res_status = ST_BLOCKED;
					state_d = S_IDLE;
				end
			end
			S_RSH: begin
				// close the gap left by the removed item
				if (stat.last) begin
					cmd.cnt_dec = 1'b1;
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d = S_RSW;
				end
			end
			S_RSW: begin
				cmd.wr_row = 1'b1;
				cmd.idx_op = IDX_INC;
				state_d = S_RSH;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mmc_datapath.sv =====
module mmc_datapath
	import mmc_pkg::*;
#(
	parameter int MAX_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic [1:0] command,
	input  logic       random_match,
	input  logic       poll,
	input  logic       commit,
	input  logic [3:0] match_mask,
	input  row_t       value,
	input  ctl_cmd_t   cmd,
	output dp_stat_t   stat,
	output logic [1:0] status,
	output row_t       got,
	output logic [4:0] occupancy,
	output logic       is_full,
	output logic       done
);

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic [4:0]      cap_q;
	logic [2:0]      fields_q;
	logic            drop_q;
	logic [1:0]      cmd_q;
	logic            rnd_q;
	logic            poll_q;
	logic            commit_q;
	logic [3:0]      mask_q;
	row_t            val_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   pos_q;
	row_t            mem [MAX_SLOTS];
	row_t            rdata_q;
	row_t            got_q;
	logic [1:0]      status_q;
	logic [4:0]      occ_q;
	logic            full_q;
	logic            done_q;

	logic [CW-1:0]         cap_eff;
	logic [NF_W-1:0]       nf;
	logic [MAX_FIELDS-1:0] fen;
	logic                  match;
	logic                  lt;
	logic                  diff_seen;
	logic [CW:0]           idx_p1;
	logic [CW-1:0]         rd_idx;
	logic [CW-1:0]         count_d;

	always_comb begin
		if (cap_q == 5'd0) begin
			cap_eff = CW'(1);
		end else if (int'(cap_q) > MAX_SLOTS) begin
			cap_eff = CW'(MAX_SLOTS);
		end else begin
			cap_eff = CW'(cap_q);
		end
		if (fields_q == 3'd0) begin
			nf = NF_W'(1);
		end else if (int'(fields_q) > MAX_FIELDS) begin
			nf = NF_W'(MAX_FIELDS);
		end else begin
			nf = fields_q;
		end
		for (int j = 0; j < MAX_FIELDS; j++) begin
			fen[j] = (NF_W'(j) < nf);
		end
	end

	always_comb begin
		match = 1'b1;
		lt = 1'b0;
		diff_seen = 1'b0;
		for (int j = 0; j < MAX_FIELDS; j++) begin
			if (fen[j] && mask_q[j] && (rdata_q[j] != val_q[j])) begin
				match = 1'b0;
			end
			// lexicographic order: first differing field decides
			if (fen[j] && !diff_seen && (rdata_q[j] != val_q[j])) begin
				diff_seen = 1'b1;
				lt = ($signed(val_q[j]) < $signed(rdata_q[j]));
			end
		end
	end

	assign idx_p1 = {1'b0, idx_q} + 1'b1;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_PREV: rd_idx = idx_q - 1'b1;
			RD_NEXT: rd_idx = idx_p1[CW-1:0];
			default: rd_idx = idx_q;
		endcase
		if (cmd.cnt_inc) begin
			count_d = count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
			fields_q <= 3'd4;
			drop_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CAPACITY: cap_q <= cfg_data;
				REG_FIELDS:   fields_q <= cfg_data[2:0];
				REG_DROP:     drop_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			rnd_q <= random_match;
			poll_q <= poll;
			commit_q <= commit;
			mask_q <= match_mask;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.pos_set) begin
				pos_q <= idx_q;
			end
			unique case (cmd.idx_op)
				IDX_ZERO:  idx_q <= '0;
				IDX_COUNT: idx_q <= count_q;
				IDX_INC:   idx_q <= idx_p1[CW-1:0];
				IDX_DEC:   idx_q <= idx_q - 1'b1;
				default:   idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_idx[AW-1:0]];
		end
		for (int j = 0; j < MAX_FIELDS; j++) begin
			if (cmd.wr_val && fen[j]) begin
				mem[idx_q[AW-1:0]][j] <= val_q[j];
			end else if (cmd.wr_row) begin
				mem[idx_q[AW-1:0]][j] <= rdata_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			got_q <= '0;
		end else if (cmd.got_ld) begin
			for (int j = 0; j < MAX_FIELDS; j++) begin
				got_q[j] <= fen[j] ? rdata_q[j] : '0;
			end
		end
		if (cmd.finish) begin
			status_q <= cmd.res_status;
			occ_q <= 5'(count_d);
			full_q <= (count_d >= cap_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_comb begin
		stat.command = cmd_q;
		stat.rnd = rnd_q;
		stat.poll = poll_q;
		stat.commit = commit_q;
		stat.drop = drop_q;
		stat.full = (count_q >= cap_eff);
		stat.empty = (count_q == '0);
		stat.at_count = (idx_q == count_q);
		stat.at_pos = (idx_q == pos_q);
		stat.last = (idx_p1 >= {1'b0, count_q});
		stat.lt = lt;
		stat.match = match;
	end

	assign status = status_q;
	assign got = got_q;
	assign occupancy = occ_q;
	assign is_full = full_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/matching_message_channel_top.sv =====
// channel  | direction | handshake                  | payload
// command  | in        | start, busy                | command .. value_3
// result   | out       | done (one-cycle strobe)    | status .. is_full
// config   | in        | cfg_write                  | cfg_index, cfg_data
//
// An append send writes the new message behind the held ones; a sorted send scans for
// its slot and shifts the later messages up, and a receive scans for a match and closes
// the gap: during the scan and the gap shift the message store alternates between reading
// one slot and comparing or writing it. Reset clears the message count and loads the
// default configuration; store contents are undefined. The result is shown with a
// one-cycle done strobe in the cycle busy falls; the receiver cannot stall.
module matching_message_channel_top
	import mmc_pkg::*;
#(
	parameter int MAX_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic        random_match,
	input  logic        poll,
	input  logic        commit,
	input  logic [3:0]  match_mask,
	input  logic signed [31:0] value_0,
	input  logic signed [31:0] value_1,
	input  logic signed [31:0] value_2,
	input  logic signed [31:0] value_3,
	output logic        done,
	output logic [1:0]  status,
	output logic signed [31:0] got_0,
	output logic signed [31:0] got_1,
	output logic signed [31:0] got_2,
	output logic signed [31:0] got_3,
	output logic [4:0]  occupancy,
	output logic        is_full
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	row_t     value;
	row_t     got;

	assign value = {value_3, value_2, value_1, value_0};
	assign got_0 = got[0];
	assign got_1 = got[1];
	assign got_2 = got[2];
	assign got_3 = got[3];

	mmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mmc_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.random_match (random_match),
		.poll         (poll),
		.commit       (commit),
		.match_mask   (match_mask),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.got          (got),
		.occupancy    (occupancy),
		.is_full      (is_full),
		.done         (done)
	);

endmodule

// ===== hw/rtl/mmc_checker.sv =====
`include "matching_message_channel_top_assert.svh"

module mmc_checker
	import mmc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] got_0,
	input logic [31:0] got_1,
	input logic [31:0] got_2,
	input logic [31:0] got_3
);

	`MMC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`MMC_ASSERT(a_done_idle, done |-> !busy)
	`MMC_ASSERT(a_done_after_work, done |-> $past(busy))
	`MMC_ASSERT(a_fail_no_data, (done && status != ST_DONE) |-> (got_0 == '0 && got_1 == '0 && got_2 == '0 && got_3 == '0))

endmodule

bind matching_message_channel_top mmc_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.got_0  (got_0),
	.got_1  (got_1),
	.got_2  (got_2),
	.got_3  (got_3)
);

// ===== tb/matching_message_channel_checker.sv =====
module matching_message_channel_checker
	import mmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic        random_match,
	input  logic        poll,
	input  logic        commit,
	input  logic [3:0]  match_mask,
	input  logic signed [31:0] value_0,
	input  logic signed [31:0] value_1,
	input  logic signed [31:0] value_2,
	input  logic signed [31:0] value_3,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic signed [31:0] got_0,
	input  logic signed [31:0] got_1,
	input  logic signed [31:0] got_2,
	input  logic signed [31:0] got_3,
	input  logic [4:0]  occupancy,
	input  logic        is_full,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;

	typedef struct {
		logic [1:0] status;
		field_t     got [MAX_FIELDS];
		logic [4:0] occupancy;
		logic       is_full;
	} outcome_t;

	logic [4:0] cap_reg;
	logic [2:0] nf_reg;
	logic       drop_reg;
	field_t     slot_mem [SLOTS][MAX_FIELDS];
	int         held;
	outcome_t   outcome_q[$];

	function automatic int eff_cap();
		if (cap_reg == 0) return 1;
		if (cap_reg > SLOTS) return SLOTS;
		return cap_reg;
	endfunction

	function automatic int eff_nf();
		if (nf_reg == 0) return 1;
		if (nf_reg > MAX_FIELDS) return MAX_FIELDS;
		return nf_reg;
	endfunction

	// Apply one command to the channel copy and return what the block should answer.
	function automatic outcome_t channel_step(logic [1:0] cmd, logic rnd, logic pl,
			logic cm, logic [3:0] mask, field_t v [MAX_FIELDS]);
		outcome_t o;
		int cap, nf, pos, scan_end, hit, c;
		bit ok;
		cap = eff_cap();
		nf = eff_nf();
		o.status = ST_BLOCKED;
		for (int j = 0; j < MAX_FIELDS; j++) o.got[j] = '0;
		if (cmd == CMD_APPEND || cmd == CMD_SORTED) begin
			if (held >= cap) begin
				o.status = drop_reg ? ST_DROPPED : ST_BLOCKED;
			end else begin
				o.status = ST_DONE;
				if (cm) begin
					pos = held;
					if (cmd == CMD_SORTED) begin
						for (pos = 0; pos < held; pos++) begin
							c = 0;
							for (int j = 0; j < nf && c == 0; j++)
								if ($signed(v[j]) < $signed(slot_mem[pos][j])) c = -1;
								else if ($signed(v[j]) > $signed(slot_mem[pos][j])) c = 1;
							if (c < 0) break;
						end
						for (int i = held; i > pos; i--) slot_mem[i] = slot_mem[i-1];
					end
					for (int j = 0; j < nf; j++) slot_mem[pos][j] = v[j];
					held++;
				end
			end
		end else if (cmd == CMD_RECEIVE && held > 0) begin
			scan_end = rnd ? held : 1;
			hit = -1;
			for (int s = 0; s < scan_end && hit < 0; s++) begin
				ok = 1;
				for (int j = 0; j < nf; j++)
					if (mask[j] && slot_mem[s][j] != v[j]) ok = 0;
				if (ok) hit = s;
			end
			if (hit >= 0) begin
				o.status = ST_DONE;
				if (cm) begin
					for (int j = 0; j < nf; j++) o.got[j] = slot_mem[hit][j];
					if (!pl) begin
						for (int i = hit; i + 1 < held; i++) slot_mem[i] = slot_mem[i+1];
						held--;
					end
				end
			end
		end
		o.occupancy = held[4:0];
		o.is_full = held >= cap;
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending = outcome_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		outcome_t e;
		field_t   v [MAX_FIELDS];
		if (!arst_n) begin
			cap_reg <= 5'd16;
			nf_reg <= 3'd4;
			drop_reg <= 1'b0;
			held = 0;
			fail_count = 0;
			result_count <= 0;
			outcome_q.delete();
		end else begin
			// results come first: a new item in the same cycle queues behind them
			if (done) begin
				result_count <= result_count + 1;
				if (outcome_q.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					e = outcome_q.pop_front();
					check_field("status", e.status, status);
					check_field("got_0", e.got[0], got_0);
					check_field("got_1", e.got[1], got_1);
					check_field("got_2", e.got[2], got_2);
					check_field("got_3", e.got[3], got_3);
					check_field("occupancy", e.occupancy, occupancy);
					check_field("is_full", e.is_full, is_full);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_CAPACITY: cap_reg <= cfg_data;
					REG_FIELDS:   nf_reg <= cfg_data[2:0];
					REG_DROP:     drop_reg <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				v[0] = value_0;
				v[1] = value_1;
				v[2] = value_2;
				v[3] = value_3;
				outcome_q.push_back(channel_step(command, random_match, poll, commit,
					match_mask, v));
			end
		end
	end

	final if (outcome_q.size() != 0) $error("%0d results never arrived", outcome_q.size());
endmodule

// ===== tb/matching_message_channel_top_test.sv =====
module matching_message_channel_top_test
	import mmc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  command = '0;
	logic        random_match = 0;
	logic        poll = 0;
	logic        commit = 0;
	logic [3:0]  match_mask = '0;
	logic signed [31:0] value_0 = '0, value_1 = '0, value_2 = '0, value_3 = '0;
	logic        done;
	logic [1:0]  status;
	logic signed [31:0] got_0, got_1, got_2, got_3;
	logic [4:0]  occupancy;
	logic        is_full;
	int          fail_count, pending, result_count;
	int          items_sent = 0;
	int          idle_cycles = 0;
	bit          gaps_on = 1;
	int          cur_nf = 4;
	logic [31:0] value_pool [8];

	always #2 clk = ~clk;

	matching_message_channel_top u_top (.*);

	matching_message_channel_checker u_chk (.*);

	// watchdog: an accepted command, a result or reset clears the count
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic issue(logic [1:0] cmd, logic rnd, logic pl, logic cm, logic [3:0] mask,
			logic [31:0] v0, logic [31:0] v1, logic [31:0] v2, logic [31:0] v3);
		int gap;
		command <= cmd;
		random_match <= rnd;
		poll <= pl;
		commit <= cm;
		match_mask <= mask;
		value_0 <= v0;
		value_1 <= v1;
		value_2 <= v2;
		value_3 <= v3;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every result is back, then let the block settle
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 9) < 8) return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	// empty the channel by head receives; extras just answer blocked
	task automatic drain();
		repeat (17) issue(CMD_RECEIVE, 0, 0, 1, 4'h0, 0, 0, 0, 0);
	endtask

	task automatic set_mode(logic [4:0] cap, logic [4:0] nf, logic [4:0] drop);
		int new_nf;
		new_nf = (nf[2:0] == 0) ? 1 : (nf[2:0] > 4 ? 4 : nf[2:0]);
		// changing the field count with messages held would expose unwritten fields
		if (new_nf != cur_nf) drain();
		quiesce();
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_FIELDS, nf);
		write_reg(REG_DROP, drop);
		cur_nf = new_nf;
	endtask

	task automatic random_items(int n);
		int r;
		logic [1:0] cmd;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 60) == 0) quiesce();
			r = $urandom_range(0, 99);
			cmd = r < 33 ? CMD_APPEND : r < 55 ? CMD_SORTED : r < 96 ? CMD_RECEIVE : CMD_UNKNOWN;
			issue(cmd, $urandom_range(0, 1), $urandom_range(0, 3) == 0,
				$urandom_range(0, 7) != 0, $urandom_range(0, 15),
				pick_value(), pick_value(), pick_value(), pick_value());
		end
	endtask

	initial begin
		value_pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h2,
			32'h7fff_ffff, 32'h8000_0000, 32'h5, 32'hffff_fffe};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty channel, extremes, ordering ties, matching forms
		issue(CMD_RECEIVE, 0, 0, 1, 4'h0, 0, 0, 0, 0);
		issue(CMD_RECEIVE, 1, 0, 1, 4'hf, 0, 0, 0, 0);
		issue(CMD_APPEND, 0, 0, 1, 4'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
		issue(CMD_APPEND, 0, 0, 1, 4'h0, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff);
		issue(CMD_SORTED, 0, 0, 1, 4'h0, 0, 0, 0, 0);
		issue(CMD_SORTED, 0, 0, 1, 4'h0, 0, 0, 0, 0);
		issue(CMD_SORTED, 0, 0, 1, 4'h0, 32'h8000_0000, 32'h8000_0000, 0, 1);
		issue(CMD_SORTED, 0, 0, 0, 4'h0, 5, 5, 5, 5);
		issue(CMD_UNKNOWN, 1, 1, 1, 4'hf, 0, 0, 0, 0);
		issue(CMD_RECEIVE, 0, 0, 1, 4'h1, 32'h1234, 0, 0, 0);
		issue(CMD_RECEIVE, 1, 1, 1, 4'h1, 32'h7fff_ffff, 0, 0, 0);
		issue(CMD_RECEIVE, 1, 0, 0, 4'h3, 0, 0, 0, 0);
		issue(CMD_RECEIVE, 1, 0, 1, 4'h3, 0, 0, 0, 0);
		issue(CMD_RECEIVE, 1, 0, 1, 4'hf, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff);
		issue(CMD_RECEIVE, 0, 1, 1, 4'h0, 0, 0, 0, 0);
		issue(CMD_RECEIVE, 0, 0, 1, 4'h0, 0, 0, 0, 0);
		random_items(130);

		set_mode(5'd16, 5'd4, 5'd1);
		random_items(110);
		// lower capacity with messages still held
		set_mode(5'd3, 5'd4, 5'd0);
		random_items(100);
		set_mode(5'd1, 5'd1, 5'd1);
		random_items(100);
		set_mode(5'd0, 5'd0, 5'd0);
		random_items(100);
		set_mode(5'd31, 5'd7, 5'd1);
		random_items(110);
		set_mode(5'd5, 5'd2, 5'd0);
		random_items(100);
		set_mode(5'd16, 5'd3, 5'd1);
		random_items(110);

		quiesce();
		$display("Ran %0d items with %0d results over eight register settings,", items_sent,
			result_count);
		$display("covering capacity and field count extremes, drops and matching receives.");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
